FILE: design/lfcd_pkg.sv
// Shared constants, types and CRC function for the length-framed CRC deframer.
package lfcd_pkg;

    localparam int unsigned MAX_FRAME   = 80;
    localparam int unsigned MIN_FRAME   = 5;
    localparam int unsigned IDX_W       = 7;
    localparam int unsigned LEN_IDX     = 2;
    localparam logic [7:0]  SYNC_RESET  = 8'hA6;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam int unsigned CRC_TOP_BIT = 15;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = 2;

    typedef enum logic [1:0] {
        ST_MID   = 2'd0,
        ST_GOOD  = 2'd1,
        ST_BAD   = 2'd2,
        ST_ABORT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [IDX_W-1:0] byte_index;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // CRC-16/XMODEM update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_TOP_BIT])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/lfcd_front.sv
// Front end: sync hunt, byte counting, length check and running CRC.
module lfcd_front
    import lfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   rx_byte,
    input  fifo_status_t fifo_st,
    output logic         push,
    output result_t      push_data
);

    logic [7:0]       sync_byte_reg, sync_byte_next;
    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] byte_count_reg, byte_count_next;
    logic [IDX_W-1:0] frame_length_reg, frame_length_next;
    logic [15:0]      crc_reg, crc_next;

    logic             accept;
    logic             emit;
    status_t          st;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] len_new;
    logic [IDX_W:0]   idx_inc;
    logic [15:0]      crc_upd;
    logic [15:0]      crc_sync;
    logic             len_bad;
    logic             at_len;

    assign in_stall = fifo_st.full;
    assign accept   = in_valid && !fifo_st.full;

    assign at_len   = (byte_count_reg == IDX_W'(LEN_IDX));
    assign len_new  = at_len ? rx_byte[IDX_W-1:0] : frame_length_reg;
    assign idx_inc  = {1'b0, byte_count_reg} + (IDX_W+1)'(1);
    assign crc_upd  = crc_byte(crc_reg, rx_byte);
    assign crc_sync = crc_byte(16'h0000, rx_byte);
    assign len_bad  = (rx_byte < 8'(MIN_FRAME)) || (rx_byte > 8'(MAX_FRAME));

    always_comb
    begin
        sync_byte_next    = cfg_wr_en ? cfg_wr_data : sync_byte_reg;
        in_frame_next     = in_frame_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        emit              = 1'b0;
        st                = ST_MID;
        idx               = byte_count_reg;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == sync_byte_reg)
                begin
                    in_frame_next   = 1'b1;
                    byte_count_next = IDX_W'(1);
                    crc_next        = crc_sync;
                    emit            = 1'b1;
                    idx             = '0;
                end
            end
            else if (byte_count_reg >= IDX_W'(MAX_FRAME))
            begin
                // overlong guard: drop silently
                in_frame_next   = 1'b0;
                byte_count_next = '0;
            end
            else if (at_len && len_bad)
            begin
                in_frame_next   = 1'b0;
                byte_count_next = '0;
                crc_next        = '0;
                emit            = 1'b1;
                st              = ST_ABORT;
            end
            else
            begin
                frame_length_next = len_new;
                crc_next          = crc_upd;
                byte_count_next   = idx_inc[IDX_W-1:0];
                emit              = 1'b1;
                if ((byte_count_reg >= IDX_W'(LEN_IDX)) && (idx_inc >= {1'b0, len_new}))
                begin
                    st              = (crc_upd == 16'h0000) ? ST_GOOD : ST_BAD;
                    in_frame_next   = 1'b0;
                    byte_count_next = '0;
                end
            end
        end
    end

    assign push                 = emit;
    assign push_data.frame_byte = rx_byte;
    assign push_data.byte_index = idx;
    assign push_data.status     = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg    <= SYNC_RESET;
            in_frame_reg     <= 1'b0;
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            crc_reg          <= '0;
        end
        else
        begin
            sync_byte_reg    <= sync_byte_next;
            in_frame_reg     <= in_frame_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
        end
    end

endmodule

FILE: design/lfcd_fifo.sv
// Short result queue between the front end and the output stage.
module lfcd_fifo
    import lfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_t      push_data,
    input  logic         pop,
    output result_t      rd_data,
    output fifo_status_t st
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign st.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign st.empty = (count_reg == '0);
    assign do_push  = push && !st.full;
    assign do_pop   = pop && !st.empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/lfcd_back.sv
// Output stage: moves queued results into the output register.
module lfcd_back
    import lfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fifo_status_t fifo_st,
    input  result_t      rd_data,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    load;

    // refill when the register is empty or its transaction completes
    assign load = !fifo_st.empty && (!out_valid_reg || !out_stall);
    assign pop  = load;

    always_comb
    begin
        out_data_next  = load ? rd_data : out_data_reg;
        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/length_framed_crc_deframer_core.sv
// Top level of the length-framed CRC-16 deframer.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   rx_byte
//   output    out        out_valid / out_stall frame_byte, byte_index, status
//   config    in         cfg_wr_en             cfg_wr_data (sync byte)
//
// One byte is taken every cycle while in_stall is low; the front end does
// the CRC update and length compare in the cycle of acceptance and writes
// the result to a four-entry queue, from which it is moved into the output
// register. out_stall holds the output register; the queue then takes up to
// four more results before in_stall rises, and in_stall is high only while
// the queue is full. Reset clears framing state and sets the sync byte to
// 0xA6.
module length_framed_crc_deframer_core
    import lfcd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       frame_byte,
    output logic [IDX_W-1:0] byte_index,
    output logic [1:0]       status
);

    fifo_status_t fifo_st;
    logic         push;
    logic         pop;
    result_t      push_data;
    result_t      rd_data;
    result_t      out_data;

    lfcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .fifo_st     (fifo_st),
        .push        (push),
        .push_data   (push_data)
    );

    lfcd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .st        (fifo_st)
    );

    lfcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_st   (fifo_st),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign frame_byte = out_data.frame_byte;
    assign byte_index = out_data.byte_index;
    assign status     = out_data.status;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_st.full))
        else $error("result pushed into a full queue");

    a_abort_at_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_ABORT)) |-> (byte_index == IDX_W'(LEN_IDX)))
        else $error("length abort reported away from the length byte");

    a_end_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == ST_GOOD) || (status == ST_BAD)))
            |-> (byte_index >= IDX_W'(MIN_FRAME - 1)))
        else $error("frame end reported before minimum length");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_index < IDX_W'(MAX_FRAME)))
        else $error("byte index beyond maximum frame");

endmodule
